@@ hw/rtl/cbc_pkg.sv @@
// ----------------------------------------------------------------------------
// cbc_pkg
// shared types and constants for the circle and box collision test core
// ----------------------------------------------------------------------------
package cbc_pkg;

	typedef enum logic {
		OP_CIRCLE = 1'b0,
		OP_BOX    = 1'b1
	} op_t;

	localparam int NRM_W   = 16;
	localparam int DEP_W   = 31;
	localparam int Q_W     = 15;
	localparam int SQ_STEPS = 32;
	localparam int REM_W   = 49;

	localparam logic signed [NRM_W-1:0] ONE_Q14 = 16'sd16384;

	typedef struct packed {
		op_t                    op;
		logic                   c_hit;
		logic                   c_zero;
		logic [DEP_W-1:0]       r;
		logic                   neg_x;
		logic                   neg_y;
		logic                   b_hit;
		logic signed [NRM_W-1:0] b_nx;
		logic signed [NRM_W-1:0] b_ny;
		logic [DEP_W-1:0]       b_depth;
	} ctx_t;

endpackage

@@ hw/rtl/cbc_solver.sv @@
// ----------------------------------------------------------------------------
// cbc_solver
// pipelined integer square root followed by two pipelined restoring dividers
// ----------------------------------------------------------------------------
module cbc_solver (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_valid,
	input  logic [63:0]                dist2,
	input  logic [31:0]                ux,
	input  logic [31:0]                uy,
	input  cbc_pkg::ctx_t              in_ctx,
	output logic                       out_valid,
	output logic [31:0]                d,
	output logic [cbc_pkg::Q_W-1:0]    qx,
	output logic [cbc_pkg::Q_W-1:0]    qy,
	output cbc_pkg::ctx_t              out_ctx
);

	localparam int NS = cbc_pkg::SQ_STEPS;
	localparam int NQ = cbc_pkg::Q_W;

	// square root stages
	logic                v_s   [0:NS];
	logic [63:0]         x_s   [0:NS];
	logic [63:0]         res_s [0:NS];
	logic [31:0]         ux_s  [0:NS];
	logic [31:0]         uy_s  [0:NS];
	cbc_pkg::ctx_t       ctx_s [0:NS];

	assign v_s[0]   = in_valid;
	assign x_s[0]   = dist2;
	assign res_s[0] = '0;
	assign ux_s[0]  = ux;
	assign uy_s[0]  = uy;
	assign ctx_s[0] = in_ctx;

	for (genvar k = 0; k < NS; k++) begin : g_sq
		localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
		logic [63:0] t;
		logic        ge;
		assign t  = res_s[k] + BIT;
		assign ge = x_s[k] >= t;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				x_s[k+1]   <= ge ? x_s[k] - t : x_s[k];
				res_s[k+1] <= ge ? (res_s[k] >> 1) + BIT : res_s[k] >> 1;
				ux_s[k+1]  <= ux_s[k];
				uy_s[k+1]  <= uy_s[k];
				ctx_s[k+1] <= ctx_s[k];
			end
		end
	end

	// divider set-up and quotient stages
	logic                          dv_s   [0:NQ];
	logic [cbc_pkg::REM_W-1:0]     rx_s   [0:NQ];
	logic [cbc_pkg::REM_W-1:0]     ry_s   [0:NQ];
	logic [32:0]                   den_s  [0:NQ];
	logic [31:0]                   d_s    [0:NQ];
	logic [NQ-1:0]                 qx_s   [0:NQ];
	logic [NQ-1:0]                 qy_s   [0:NQ];
	cbc_pkg::ctx_t                 dctx_s [0:NQ];

	logic [31:0] root;
	assign root = res_s[NS][31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_s[0] <= 1'b0;
		end else if (en) begin
			dv_s[0] <= v_s[NS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rx_s[0]   <= {2'b0, ux_s[NS], 15'b0} + {17'b0, root};
			ry_s[0]   <= {2'b0, uy_s[NS], 15'b0} + {17'b0, root};
			den_s[0]  <= {root, 1'b0};
			d_s[0]    <= root;
			qx_s[0]   <= '0;
			qy_s[0]   <= '0;
			dctx_s[0] <= ctx_s[NS];
		end
	end

	for (genvar j = 0; j < NQ; j++) begin : g_dv
		logic [cbc_pkg::REM_W-1:0] sh;
		logic                      gx;
		logic                      gy;
		assign sh = {16'b0, den_s[j]} << (NQ - 1 - j);
		assign gx = rx_s[j] >= sh;
		assign gy = ry_s[j] >= sh;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_s[j+1] <= 1'b0;
			end else if (en) begin
				dv_s[j+1] <= dv_s[j];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rx_s[j+1]   <= gx ? rx_s[j] - sh : rx_s[j];
				ry_s[j+1]   <= gy ? ry_s[j] - sh : ry_s[j];
				qx_s[j+1]   <= qx_s[j] | (NQ'(gx) << (NQ - 1 - j));
				qy_s[j+1]   <= qy_s[j] | (NQ'(gy) << (NQ - 1 - j));
				den_s[j+1]  <= den_s[j];
				d_s[j+1]    <= d_s[j];
				dctx_s[j+1] <= dctx_s[j];
			end
		end
	end

	assign out_valid = dv_s[NQ];
	assign d         = d_s[NQ];
	assign qx        = qx_s[NQ];
	assign qy        = qy_s[NQ];
	assign out_ctx   = dctx_s[NQ];

endmodule

@@ hw/rtl/circle_and_box_collision_test_core.sv @@
// pipeline: 3 front stages, 32 square root stages, 1 divider set-up stage, 15 divider stages
// and 1 output register from input item to result item
// throughput: one item per cycle; the whole pipeline stalls together while the
// output item is held back by m_tready
// reset: arst_n clears every valid bit at once; payload registers keep no reset
// ----------------------------------------------------------------------------
// circle_and_box_collision_test_core
// circle against circle and box against box overlap test with contact normal
// ----------------------------------------------------------------------------
module circle_and_box_collision_test_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [247:0]  s_tdata,  // a_x, a_y, b_x, b_y, a_ext_x, a_ext_y, b_ext_x, b_ext_y, pad
	input  logic [0:0]    s_tuser,  // op
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [63:0]   m_tdata,  // normal_x, normal_y, depth, pad
	output logic [0:0]    m_tuser   // hit
);

	logic en;
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	logic signed [30:0] a_x, a_y, b_x, b_y;
	logic [29:0]        a_ext_x, a_ext_y, b_ext_x, b_ext_y;
	assign a_x     = s_tdata[30:0];
	assign a_y     = s_tdata[61:31];
	assign b_x     = s_tdata[92:62];
	assign b_y     = s_tdata[123:93];
	assign a_ext_x = s_tdata[153:124];
	assign a_ext_y = s_tdata[183:154];
	assign b_ext_x = s_tdata[213:184];
	assign b_ext_y = s_tdata[243:214];

	// stage 1: offsets and extent sums
	logic                v_s1;
	cbc_pkg::op_t        op_s1;
	logic                negx_s1, negy_s1;
	logic [31:0]         ux_s1, uy_s1;
	logic [30:0]         r_s1, ey_s1;

	logic signed [31:0] dx, dy;
	assign dx = 32'(b_x) - 32'(a_x);
	assign dy = 32'(b_y) - 32'(a_y);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1   <= cbc_pkg::op_t'(s_tuser[0]);
			negx_s1 <= dx[31];
			negy_s1 <= dy[31];
			ux_s1   <= dx[31] ? 32'(-dx) : 32'(dx);
			uy_s1   <= dy[31] ? 32'(-dy) : 32'(dy);
			r_s1    <= 31'(a_ext_x) + 31'(b_ext_x);
			ey_s1   <= 31'(a_ext_y) + 31'(b_ext_y);
		end
	end

	// stage 2: squares and box overlaps
	logic                v_s2;
	cbc_pkg::op_t        op_s2;
	logic                negx_s2, negy_s2;
	logic [31:0]         ux_s2, uy_s2;
	logic [30:0]         r_s2;
	logic [63:0]         sx_s2, sy_s2;
	logic [61:0]         rr_s2;
	logic signed [32:0]  ox_s2, oy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s2   <= op_s1;
			negx_s2 <= negx_s1;
			negy_s2 <= negy_s1;
			ux_s2   <= ux_s1;
			uy_s2   <= uy_s1;
			r_s2    <= r_s1;
			sx_s2   <= 64'(ux_s1) * 64'(ux_s1);
			sy_s2   <= 64'(uy_s1) * 64'(uy_s1);
			rr_s2   <= 62'(r_s1) * 62'(r_s1);
			ox_s2   <= $signed({2'b0, r_s1}) - $signed({1'b0, ux_s1});
			oy_s2   <= $signed({2'b0, ey_s1}) - $signed({1'b0, uy_s1});
		end
	end

	// stage 3: distance compare and box decision
	logic                v_s3;
	logic [63:0]         d2_s3;
	logic [31:0]         ux_s3, uy_s3;
	cbc_pkg::ctx_t       ctx_s3;

	logic [63:0]   d2;
	cbc_pkg::ctx_t ctx_n;
	logic          xmin;
	assign d2   = sx_s2 + sy_s2;
	assign xmin = ox_s2 < oy_s2;

	always_comb begin
		ctx_n         = '0;
		ctx_n.op      = op_s2;
		ctx_n.c_hit   = d2 <= 64'(rr_s2);
		ctx_n.c_zero  = d2 == 64'd0;
		ctx_n.r       = r_s2;
		ctx_n.neg_x   = negx_s2;
		ctx_n.neg_y   = negy_s2;
		ctx_n.b_hit   = (ox_s2 > 33'sd0) && (oy_s2 > 33'sd0);
		// box normal points from a to b, equal centres give the negative axis
		if (xmin) begin
			ctx_n.b_nx    = (negx_s2 || ux_s2 == 32'd0) ? -cbc_pkg::ONE_Q14 : cbc_pkg::ONE_Q14;
			ctx_n.b_depth = 31'(ox_s2);
		end else begin
			ctx_n.b_ny    = (negy_s2 || uy_s2 == 32'd0) ? -cbc_pkg::ONE_Q14 : cbc_pkg::ONE_Q14;
			ctx_n.b_depth = 31'(oy_s2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d2_s3  <= d2;
			ux_s3  <= ux_s2;
			uy_s3  <= uy_s2;
			ctx_s3 <= ctx_n;
		end
	end

	// square root and normal division
	logic                         sv;
	logic [31:0]                  sd;
	logic [cbc_pkg::Q_W-1:0]      sqx, sqy;
	cbc_pkg::ctx_t                sctx;

	cbc_solver u_solver (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s3),
		.dist2     (d2_s3),
		.ux        (ux_s3),
		.uy        (uy_s3),
		.in_ctx    (ctx_s3),
		.out_valid (sv),
		.d         (sd),
		.qx        (sqx),
		.qy        (sqy),
		.out_ctx   (sctx)
	);

	// result selection
	logic                         hit;
	logic signed [15:0]           nx, ny;
	logic [30:0]                  dep;
	logic signed [15:0]           mx, my;

	assign mx = (sqx > 15'(cbc_pkg::ONE_Q14)) ? cbc_pkg::ONE_Q14 : $signed({1'b0, sqx});
	assign my = (sqy > 15'(cbc_pkg::ONE_Q14)) ? cbc_pkg::ONE_Q14 : $signed({1'b0, sqy});

	always_comb begin
		hit = 1'b0;
		nx  = '0;
		ny  = '0;
		dep = '0;
		unique case (sctx.op)
			cbc_pkg::OP_CIRCLE: begin
				if (sctx.c_hit) begin
					hit = 1'b1;
					if (sctx.c_zero) begin
						nx  = cbc_pkg::ONE_Q14;
						dep = sctx.r;
					end else begin
						nx  = sctx.neg_x ? -mx : mx;
						ny  = sctx.neg_y ? -my : my;
						dep = sctx.r - sd[30:0];
					end
				end
			end
			cbc_pkg::OP_BOX: begin
				if (sctx.b_hit) begin
					hit = 1'b1;
					nx  = sctx.b_nx;
					ny  = sctx.b_ny;
					dep = sctx.b_depth;
				end
			end
			default: begin
				hit = 1'b0;
			end
		endcase
	end

	logic        out_v_q;
	logic [63:0] out_d_q;
	logic        out_h_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= sv;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_d_q <= {1'b0, dep, ny, nx};
			out_h_q <= hit;
		end
	end

	assign m_tvalid   = out_v_q;
	assign m_tdata    = out_d_q;
	assign m_tuser[0] = out_h_q;

endmodule

@@ hw/rtl/cbc_checker.sv @@
// ----------------------------------------------------------------------------
// cbc_checker
// port-level checks for the collision test core
// ----------------------------------------------------------------------------
module cbc_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          s_tvalid,
	input logic          s_tready,
	input logic [247:0]  s_tdata,
	input logic [0:0]    s_tuser,
	input logic          m_tvalid,
	input logic          m_tready,
	input logic [63:0]   m_tdata,
	input logic [0:0]    m_tuser
);

	// held item while stalled
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output item changed while stalled");

	// offered input item waits unchanged
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser))
		else $error("input item changed while waiting");

	// input side only stalls when the output is blocked
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("ready does not follow output stall");

	// a miss carries no normal and no depth
	a_miss: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata == 64'd0)
		else $error("miss item with non-zero payload");

	// normal components stay within one in q1.14
	a_norm: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[15:0]) >= -16'sd16384)
			&& ($signed(m_tdata[15:0]) <= 16'sd16384)
			&& ($signed(m_tdata[31:16]) >= -16'sd16384)
			&& ($signed(m_tdata[31:16]) <= 16'sd16384))
		else $error("normal out of range");

endmodule

bind circle_and_box_collision_test_core cbc_checker u_cbc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

@@ tb/tb_circle_and_box_collision_test_core.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_circle_and_box_collision_test_core
// stream testbench: a directed table of shape pairs, then near-contact and
// full-range random pairs, each result checked against its table entry or a
// behavioural collision predictor, with random stalls on both sides
// ----------------------------------------------------------------------------
module tb_circle_and_box_collision_test_core;

	typedef struct {
		cbc_pkg::op_t        op;
		logic signed [30:0]  ax, ay, bx, by;
		logic [29:0]         aex, aey, bex, bey;
	} pair_t;

	typedef struct {
		logic               hit;
		logic signed [15:0] nx, ny;
		logic [30:0]        depth;
	} contact_t;

	typedef struct {
		pair_t    p;
		logic     typed;
		contact_t c;
	} row_t;

	localparam int N_RAND = 1950;
	localparam int LIMIT  = 200000;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [247:0] s_tdata;
	logic [0:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [63:0]  m_tdata;
	logic [0:0]   m_tuser;

	pair_t    cur = '{cbc_pkg::OP_CIRCLE, 0, 0, 0, 0, 0, 0, 0, 0};
	logic     cur_typed = 1'b0;
	contact_t cur_exp = '{0, 0, 0, 0};
	contact_t contact_q[$];
	int       n_acc = 0;
	int       n_err = 0;
	int       cycles = 0;
	bit       sent_all = 0;
	row_t     rows[$];

	assign s_tdata = {4'b0, cur.bey, cur.bex, cur.aey, cur.aex, cur.by, cur.bx, cur.ay, cur.ax};
	assign s_tuser = cur.op;

	circle_and_box_collision_test_core i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic longint unsigned int_sqrt(longint unsigned x);
		longint unsigned res = 0;
		longint unsigned b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= res + b) begin
				x = x - (res + b);
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic longint unit_comp(longint c, longint unsigned d);
		longint unsigned mag = (c < 0) ? -c : c;
		longint unsigned q = (mag * 2 * 16384 + d) / (2 * d);
		if (q > 16384) q = 16384;
		return (c < 0) ? -longint'(q) : longint'(q);
	endfunction

	function automatic contact_t predict_contact(pair_t p);
		contact_t res = '{0, 0, 0, 0};
		longint ax = p.ax, ay = p.ay, bx = p.bx, by = p.by;
		longint aex = p.aex, aey = p.aey, bex = p.bex, bey = p.bey;
		longint dx, dy, ox, oy, dep;
		longint unsigned r, ux, uy, d2, d;
		dep = 0;
		if (p.op == cbc_pkg::OP_CIRCLE) begin
			dx = bx - ax;
			dy = by - ay;
			r = aex + bex;
			ux = (dx < 0) ? -dx : dx;
			uy = (dy < 0) ? -dy : dy;
			d2 = ux * ux + uy * uy;
			if (d2 <= r * r) begin
				res.hit = 1'b1;
				if (d2 == 0) begin
					dep = r;
					res.nx = cbc_pkg::ONE_Q14;
				end else begin
					d = int_sqrt(d2);
					dep = longint'(r) - longint'(d);
					res.nx = 16'(unit_comp(dx, d));
					res.ny = 16'(unit_comp(dy, d));
				end
			end
		end else begin
			dx = ax - bx;
			dy = ay - by;
			ox = aex + bex - ((dx < 0) ? -dx : dx);
			oy = aey + bey - ((dy < 0) ? -dy : dy);
			if (ox > 0 && oy > 0) begin
				res.hit = 1'b1;
				if (ox < oy) begin
					res.nx = (dx < 0) ? cbc_pkg::ONE_Q14 : -cbc_pkg::ONE_Q14;
					dep = ox;
				end else begin
					res.ny = (dy < 0) ? cbc_pkg::ONE_Q14 : -cbc_pkg::ONE_Q14;
					dep = oy;
				end
			end
		end
		if (dep < 0) dep = 0;
		if (dep > 64'd2147483647) dep = 64'd2147483647;
		res.depth = res.hit ? dep[30:0] : 31'd0;
		return res;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		n_err++;
	endtask

	function automatic row_t mk(cbc_pkg::op_t op, longint ax, longint ay, longint bx,
		longint by, longint aex, longint aey, longint bex, longint bey, logic typed,
		logic h, longint nx, longint ny, longint dep);
		row_t r;
		r.p = '{op, ax[30:0], ay[30:0], bx[30:0], by[30:0],
			aex[29:0], aey[29:0], bex[29:0], bey[29:0]};
		r.typed = typed;
		r.c = '{h, nx[15:0], ny[15:0], dep[30:0]};
		return r;
	endfunction

	function automatic pair_t rand_pair();
		pair_t p;
		longint rng, e[4], o[2];
		int s;
		p.op = cbc_pkg::op_t'($urandom_range(0, 1));
		if ($urandom_range(0, 9) < 7) begin
			s = $urandom_range(2, 29);
			rng = 64'd1 << s;
			foreach (e[i]) e[i] = $urandom & (rng - 1);
			foreach (o[i]) o[i] = longint'($urandom_range(0, 4 * rng)) - 2 * rng;
			p.ax = 31'($urandom);
			p.ay = 31'($urandom);
			p.bx = 31'(longint'(p.ax) + o[0]);
			p.by = 31'(longint'(p.ay) + o[1]);
			p.aex = 30'(e[0]); p.aey = 30'(e[1]); p.bex = 30'(e[2]); p.bey = 30'(e[3]);
		end else begin
			p.ax = 31'($urandom); p.ay = 31'($urandom);
			p.bx = 31'($urandom); p.by = 31'($urandom);
			p.aex = 30'($urandom); p.aey = 30'($urandom);
			p.bex = 30'($urandom); p.bey = 30'($urandom);
		end
		return p;
	endfunction

	// input side
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && s_tvalid && s_tready) begin
			contact_q.push_back(cur_typed ? cur_exp : predict_contact(cur));
			n_acc <= n_acc + 1;
		end
	end

	// output side
	always @(posedge clk) begin
		contact_t w;
		if (arst_n && m_tvalid && m_tready) begin
			if (contact_q.size() == 0) begin
				report_mismatch("unexpected item", 1, 0);
			end else begin
				w = contact_q.pop_front();
				if (m_tuser[0] !== w.hit) report_mismatch("hit", m_tuser[0], w.hit);
				if ($signed(m_tdata[15:0]) !== w.nx)
					report_mismatch("normal_x", $signed(m_tdata[15:0]), w.nx);
				if ($signed(m_tdata[31:16]) !== w.ny)
					report_mismatch("normal_y", $signed(m_tdata[31:16]), w.ny);
				if (m_tdata[62:32] !== w.depth) report_mismatch("depth", m_tdata[62:32], w.depth);
			end
		end
	end

	initial begin
		forever begin
			@(negedge clk);
			m_tready = (cycles > 6000 && cycles < 8000) ? 1'b1 : ($urandom_range(0, 99) >= 16);
		end
	end

	initial begin
		longint M = 64'd1073741823, N = -64'd1073741824;
		pair_t p;
		int k;
		rows.push_back(mk(cbc_pkg::OP_CIRCLE, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 16384, 0, 0));
		rows.push_back(mk(cbc_pkg::OP_CIRCLE, N, M, N, M, M, M, M, M,
			1, 1, 16384, 0, 2147483646));
		rows.push_back(mk(cbc_pkg::OP_CIRCLE, N, 0, M, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0));
		rows.push_back(mk(cbc_pkg::OP_CIRCLE, N, N, M, M, M, 0, M, 0, 1, 0, 0, 0, 0));
		rows.push_back(mk(cbc_pkg::OP_CIRCLE, 0, 0, 'h30000, 0, 'h10000, 0, 'h20000, 0,
			1, 1, 16384, 0, 0));
		rows.push_back(mk(cbc_pkg::OP_CIRCLE, 0, 0, 0, -'h10000, 'h20000, M, 'h20000, M,
			1, 1, 0, -16384, 'h30000));
		rows.push_back(mk(cbc_pkg::OP_CIRCLE, 'h1234, -'h5678, 'h9abc, 'h4321, 'h8000, 0,
			'h9000, 0, 0, 0, 0, 0, 0));
		rows.push_back(mk(cbc_pkg::OP_CIRCLE, -'h100, 'h200, 'h300, -'h50, 1, 5, 'h400, 0,
			0, 0, 0, 0, 0));
		rows.push_back(mk(cbc_pkg::OP_BOX, 0, 0, 'h20000, 0, 'h10000, 1, 'h10000, 1,
			1, 0, 0, 0, 0));
		rows.push_back(mk(cbc_pkg::OP_BOX, 0, 0, 'h10000, 0, 'h10000, 'h20000, 'h10000, 'h20000,
			1, 1, 16384, 0, 'h10000));
		rows.push_back(mk(cbc_pkg::OP_BOX, 'h10000, 0, 0, 0, 'h10000, 'h20000, 'h10000, 'h20000,
			1, 1, -16384, 0, 'h10000));
		rows.push_back(mk(cbc_pkg::OP_BOX, 5, 5, 5, 5, 'h10000, 'h10000, 'h10000, 'h10000,
			1, 1, 0, -16384, 'h20000));
		rows.push_back(mk(cbc_pkg::OP_BOX, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0));
		rows.push_back(mk(cbc_pkg::OP_BOX, N, 0, M, 0, M, M, M, M, 1, 0, 0, 0, 0));
		rows.push_back(mk(cbc_pkg::OP_BOX, M, M, M, M, M, M, M, M,
			1, 1, 0, -16384, 2147483646));
		rows.push_back(mk(cbc_pkg::OP_BOX, 0, 0, 0, 'h100, M, 'h90, 0, 'h90, 0, 0, 0, 0, 0));
		rows.push_back(mk(cbc_pkg::OP_BOX, -'h7000, 'h3000, 'h1000, -'h2000,
			'h5000, 'h6000, 'h4000, 'h3000, 0, 0, 0, 0, 0));

		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		k = 0;
		for (int i = 0; i < rows.size() + N_RAND; i++) begin
			if (i < rows.size()) begin
				p = rows[i].p;
			end else begin
				p = rand_pair();
			end
			// no idling across a long middle stretch
			while (!(i > 800 && i < 1200) && $urandom_range(0, 99) < 16) begin
				s_tvalid = 1'b0;
				@(negedge clk);
			end
			cur = p;
			cur_typed = (i < rows.size()) ? rows[i].typed : 1'b0;
			if (i < rows.size()) cur_exp = rows[i].c;
			s_tvalid = 1'b1;
			k++;
			do @(negedge clk); while (n_acc != k);
		end
		s_tvalid = 1'b0;
		sent_all = 1;
	end

	initial begin
		wait (sent_all && contact_q.size() == 0);
		repeat (60) @(posedge clk);
		if (n_err == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	initial begin
		wait (cycles >= LIMIT);
		$display("timeout");
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
